// ===== src/hsv2rgb_pkg.sv =====
// Package for the HSV to RGB converter: pixel types, fixed-point constants and sector codes.
// No dependencies; the converter top level uses it by scoped names.
package hsv2rgb_pkg;

	typedef struct packed {
		logic [15:0] hue;
		logic [7:0]  saturation;
		logic [7:0]  brightness;
	} hsv_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// Full-scale denominator 255 * 65536 and its half for rounding.
	localparam logic [23:0] FULL_DEN = 24'd16711680;
	localparam logic [31:0] HALF_DEN = 32'd8355840;
	localparam logic [16:0] FRAC_ONE = 17'h10000;
	localparam logic [7:0]  CH_MAX   = 8'd255;

	// Lanes of the shared arithmetic: p, q and t.
	localparam int NUM_LANES = 3;
	localparam int LANE_P    = 0;
	localparam int LANE_Q    = 1;
	localparam int LANE_T    = 2;

	localparam logic [2:0] SECTOR_0 = 3'd0;
	localparam logic [2:0] SECTOR_1 = 3'd1;
	localparam logic [2:0] SECTOR_2 = 3'd2;
	localparam logic [2:0] SECTOR_3 = 3'd3;
	localparam logic [2:0] SECTOR_4 = 3'd4;

endpackage

// ===== src/hsv_to_rgb_converter_top.sv =====
// HSV to RGB converter top level: a five-stage pipeline with one item per clock.
// Depends on hsv2rgb_pkg for the pixel types, constants and sector codes.
//
// One HSV item enters at every clock edge where start is high; busy is always low. The RGB item
// appears on rgb with done high for one cycle, after passing the five register stages, and one
// result leaves per cycle in entry order. The five register stages are: sector split, saturation
// products, brightness products, reciprocal estimate of the division by 255, and the remainder
// correction with sector routing. The receiver cannot stall the block.
module hsv_to_rgb_converter_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  hsv2rgb_pkg::hsv_t hsv,
	output logic              done,
	output hsv2rgb_pkg::rgb_t rgb
);

	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [2:0]  sector_s1, sector_s2, sector_s3, sector_s4;
	logic [7:0]  v_s1, v_s2, v_s3, v_s4;
	logic [7:0]  sat_s1;
	logic [15:0] f_s1;
	logic [16:0] fc_s1;
	logic [23:0] d_s2  [hsv2rgb_pkg::NUM_LANES];
	logic [15:0] n1_s3 [hsv2rgb_pkg::NUM_LANES];
	logic [15:0] n1_s4 [hsv2rgb_pkg::NUM_LANES];
	logic [7:0]  qe_s4 [hsv2rgb_pkg::NUM_LANES];
	hsv2rgb_pkg::rgb_t rgb_s5;

	logic [18:0] hue_x6;
	logic [24:0] k_lane   [hsv2rgb_pkg::NUM_LANES];
	logic [24:0] d_lane   [hsv2rgb_pkg::NUM_LANES];
	logic [31:0] n_lane   [hsv2rgb_pkg::NUM_LANES];
	logic [23:0] est_lane [hsv2rgb_pkg::NUM_LANES];
	logic [17:0] rem_lane [hsv2rgb_pkg::NUM_LANES];
	logic [7:0]  res_lane [hsv2rgb_pkg::NUM_LANES];
	hsv2rgb_pkg::rgb_t rgb_next;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Stage 1: hue times six splits into sector and fraction.
	assign hue_x6 = {1'b0, hsv.hue, 2'b00} + {2'b00, hsv.hue, 1'b0};

	always_ff @(posedge clk) begin
		sector_s1 <= hue_x6[18:16];
		f_s1      <= hue_x6[15:0];
		fc_s1     <= hsv2rgb_pkg::FRAC_ONE - {1'b0, hue_x6[15:0]};
		sat_s1    <= hsv.saturation;
		v_s1      <= hsv.brightness;
	end

	// Stage 2: saturation terms subtracted from the full-scale denominator.
	always_comb begin
		k_lane[hsv2rgb_pkg::LANE_P] = {1'b0, sat_s1, 16'd0};
		k_lane[hsv2rgb_pkg::LANE_Q] = {17'd0, sat_s1} * {9'd0, f_s1};
		k_lane[hsv2rgb_pkg::LANE_T] = {17'd0, sat_s1} * {8'd0, fc_s1};
		for (int i = 0; i < hsv2rgb_pkg::NUM_LANES; i++) begin
			d_lane[i] = {1'b0, hsv2rgb_pkg::FULL_DEN} - k_lane[i];
		end
	end

	always_ff @(posedge clk) begin
		sector_s2 <= sector_s1;
		v_s2      <= v_s1;
		for (int i = 0; i < hsv2rgb_pkg::NUM_LANES; i++) begin
			d_s2[i] <= d_lane[i][23:0];
		end
	end

	// Stage 3: scale by brightness with rounding; the low 16 bits of the denominator drop here.
	always_comb begin
		for (int i = 0; i < hsv2rgb_pkg::NUM_LANES; i++) begin
			n_lane[i] = {24'd0, v_s2} * {8'd0, d_s2[i]} + hsv2rgb_pkg::HALF_DEN;
		end
	end

	always_ff @(posedge clk) begin
		sector_s3 <= sector_s2;
		v_s3      <= v_s2;
		for (int i = 0; i < hsv2rgb_pkg::NUM_LANES; i++) begin
			n1_s3[i] <= n_lane[i][31:16];
		end
	end

	// Stage 4: quotient estimate by 255 as multiplication by 257 / 65536, never above the true one.
	always_comb begin
		for (int i = 0; i < hsv2rgb_pkg::NUM_LANES; i++) begin
			est_lane[i] = {8'd0, n1_s3[i]} + {n1_s3[i], 8'd0};
		end
	end

	always_ff @(posedge clk) begin
		sector_s4 <= sector_s3;
		v_s4      <= v_s3;
		for (int i = 0; i < hsv2rgb_pkg::NUM_LANES; i++) begin
			n1_s4[i] <= n1_s3[i];
			qe_s4[i] <= est_lane[i][23:16];
		end
	end

	// Stage 5: one correction step, then routing by sector. Zero saturation yields v in every lane.
	always_comb begin
		for (int i = 0; i < hsv2rgb_pkg::NUM_LANES; i++) begin
			rem_lane[i] = {2'b00, n1_s4[i]} - {2'b00, qe_s4[i], 8'd0} + {10'd0, qe_s4[i]};
			res_lane[i] = qe_s4[i] + {7'd0, (rem_lane[i] >= {10'd0, hsv2rgb_pkg::CH_MAX})};
		end
		case (sector_s4)
			hsv2rgb_pkg::SECTOR_0: begin
				rgb_next.red   = v_s4;
				rgb_next.green = res_lane[hsv2rgb_pkg::LANE_T];
				rgb_next.blue  = res_lane[hsv2rgb_pkg::LANE_P];
			end
			hsv2rgb_pkg::SECTOR_1: begin
				rgb_next.red   = res_lane[hsv2rgb_pkg::LANE_Q];
				rgb_next.green = v_s4;
				rgb_next.blue  = res_lane[hsv2rgb_pkg::LANE_P];
			end
			hsv2rgb_pkg::SECTOR_2: begin
				rgb_next.red   = res_lane[hsv2rgb_pkg::LANE_P];
				rgb_next.green = v_s4;
				rgb_next.blue  = res_lane[hsv2rgb_pkg::LANE_T];
			end
			hsv2rgb_pkg::SECTOR_3: begin
				rgb_next.red   = res_lane[hsv2rgb_pkg::LANE_P];
				rgb_next.green = res_lane[hsv2rgb_pkg::LANE_Q];
				rgb_next.blue  = v_s4;
			end
			hsv2rgb_pkg::SECTOR_4: begin
				rgb_next.red   = res_lane[hsv2rgb_pkg::LANE_T];
				rgb_next.green = res_lane[hsv2rgb_pkg::LANE_P];
				rgb_next.blue  = v_s4;
			end
			default: begin
				rgb_next.red   = v_s4;
				rgb_next.green = res_lane[hsv2rgb_pkg::LANE_P];
				rgb_next.blue  = res_lane[hsv2rgb_pkg::LANE_Q];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rgb_s5 <= rgb_next;
	end

	assign done = valid_s5;
	assign rgb  = rgb_s5;

endmodule

// ===== tb/tb_hsv_to_rgb_converter_top.sv =====
// Self-checking testbench for hsv_to_rgb_converter_top: directed and random HSV items are
// checked against an in-bench fixed-point HSV to RGB predictor, with random gaps on the input.
// Depends on hsv2rgb_pkg for the pixel types, constants and sector codes.
module tb_hsv_to_rgb_converter_top;

	typedef struct {
		hsv2rgb_pkg::hsv_t px;
		int unsigned       gap_pct;
	} pixel_job_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	hsv2rgb_pkg::hsv_t hsv = '0;
	logic              busy;
	logic              done;
	hsv2rgb_pkg::rgb_t rgb;

	pixel_job_t        pending_q[$];
	hsv2rgb_pkg::rgb_t rgb_expected_q[$];
	int                fail_count = 0;

	hsv_to_rgb_converter_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.hsv    (hsv),
		.done   (done),
		.rgb    (rgb)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] scale_brightness(logic [63:0] v, logic [63:0] k);
		logic [63:0] den;
		den = 64'(hsv2rgb_pkg::FULL_DEN);
		return (v * (den - k) + den / 2) / den;
	endfunction

	function automatic hsv2rgb_pkg::rgb_t hsv_pixel_to_rgb(hsv2rgb_pkg::hsv_t px);
		logic [63:0]       v;
		logic [63:0]       s;
		logic [63:0]       x;
		logic [63:0]       f;
		logic [63:0]       one;
		logic [7:0]        p;
		logic [7:0]        q;
		logic [7:0]        t;
		logic [2:0]        sector;
		hsv2rgb_pkg::rgb_t res;
		v = 64'(px.brightness);
		s = 64'(px.saturation);
		one = 64'(hsv2rgb_pkg::FRAC_ONE);
		if (s == 0) begin
			res.red = px.brightness;
			res.green = px.brightness;
			res.blue = px.brightness;
			return res;
		end
		x = 64'(px.hue) * 64'd6;
		sector = x[18:16];
		f = 64'(x[15:0]);
		p = 8'(scale_brightness(v, s * one));
		q = 8'(scale_brightness(v, s * f));
		t = 8'(scale_brightness(v, s * (one - f)));
		case (sector)
			hsv2rgb_pkg::SECTOR_0: res = '{px.brightness, t, p};
			hsv2rgb_pkg::SECTOR_1: res = '{q, px.brightness, p};
			hsv2rgb_pkg::SECTOR_2: res = '{p, px.brightness, t};
			hsv2rgb_pkg::SECTOR_3: res = '{p, q, px.brightness};
			hsv2rgb_pkg::SECTOR_4: res = '{t, p, px.brightness};
			default:               res = '{px.brightness, p, q};
		endcase
		return res;
	endfunction

	function automatic logic [7:0] pick_channel();
		case ($urandom_range(15))
			0, 1:    return 8'd0;
			2:       return 8'd255;
			3:       return 8'd1;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [15:0] pick_hue();
		case ($urandom_range(15))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(5) * 10923 + $urandom_range(2) - 1);
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	task automatic queue_pixel(logic [15:0] h, logic [7:0] s, logic [7:0] v, int unsigned gap);
		pixel_job_t job;
		job.px.hue = h;
		job.px.saturation = s;
		job.px.brightness = v;
		job.gap_pct = gap;
		pending_q.push_back(job);
	endtask

	always @(posedge clk) begin : drive_proc
		pixel_job_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				rgb_expected_q.push_back(hsv_pixel_to_rgb(hsv));
			end
			if (!start || !busy) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= pending_q[0].gap_pct) begin
					nxt = pending_q.pop_front();
					hsv <= nxt.px;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_proc
		hsv2rgb_pkg::rgb_t want;
		if (arst_n && done) begin
			if (rgb_expected_q.size() == 0) begin
				$error("unexpected result item: red %0d green %0d blue %0d",
					rgb.red, rgb.green, rgb.blue);
				fail_count++;
			end else begin
				want = rgb_expected_q.pop_front();
				if (rgb.red !== want.red) begin
					$error("red mismatch: expected %0d, actual %0d", want.red, rgb.red);
					fail_count++;
				end
				if (rgb.green !== want.green) begin
					$error("green mismatch: expected %0d, actual %0d", want.green, rgb.green);
					fail_count++;
				end
				if (rgb.blue !== want.blue) begin
					$error("blue mismatch: expected %0d, actual %0d", want.blue, rgb.blue);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#1000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int unsigned gap;
		queue_pixel(16'h0000, 8'd255, 8'd255, 17);
		queue_pixel(16'hFFFF, 8'd255, 8'd255, 17);
		queue_pixel(16'h0000, 8'd0, 8'd0, 17);
		queue_pixel(16'h0000, 8'd0, 8'd255, 17);
		queue_pixel(16'h1234, 8'd0, 8'd128, 17);
		queue_pixel(16'hFFFF, 8'd0, 8'd77, 17);
		queue_pixel(16'd10922, 8'd255, 8'd255, 17);
		queue_pixel(16'd10923, 8'd255, 8'd255, 17);
		queue_pixel(16'd21845, 8'd200, 8'd200, 17);
		queue_pixel(16'd21846, 8'd200, 8'd200, 17);
		queue_pixel(16'd32767, 8'd255, 8'd180, 17);
		queue_pixel(16'd32768, 8'd255, 8'd180, 17);
		queue_pixel(16'd43690, 8'd90, 8'd255, 17);
		queue_pixel(16'd43691, 8'd90, 8'd255, 17);
		queue_pixel(16'd54613, 8'd255, 8'd255, 17);
		queue_pixel(16'd54614, 8'd255, 8'd255, 17);
		queue_pixel(16'hFFFF, 8'd1, 8'd255, 17);
		queue_pixel(16'h8000, 8'd1, 8'd1, 17);
		queue_pixel(16'hAAAA, 8'd255, 8'd0, 17);
		queue_pixel(16'h5555, 8'd128, 8'd127, 17);
		queue_pixel(16'h0001, 8'd255, 8'd255, 17);
		queue_pixel(16'hFFFE, 8'd254, 8'd254, 17);
		for (int i = 0; i < 1000; i++) begin
			gap = (i < 333) ? 17 : (i < 666) ? 73 : 0;
			queue_pixel(pick_hue(), pick_channel(), pick_channel(), gap);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (pending_q.size() != 0 || start || rgb_expected_q.size() != 0);
		repeat (10) @(posedge clk);

		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/hsv2rgb_pkg.sv
src/hsv_to_rgb_converter_top.sv
tb/tb_hsv_to_rgb_converter_top.sv
